>>> sv/fkc_pkg.sv
// Package for the FASTA k-mer counter: token types, field widths and text codes.
// Depends on nothing; every other file of the block imports it.
package fkc_pkg;

    localparam int KEY_W       = 64;
    localparam int OUT_COUNT_W = 24;
    localparam int IDX_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int KLEN_W      = 4;
    localparam int POS_W       = 4;

    localparam logic [BYTE_W-1:0] CHAR_HEADER  = 8'h3E;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

    localparam logic OP_STREAM = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Output beat layout, lowest bit first.
    localparam int OUT_KEY_LSB   = 0;
    localparam int OUT_COUNT_LSB = KEY_W;
    localparam int OUT_VALID_BIT = KEY_W + OUT_COUNT_W;
    localparam int OUT_OVF_BIT   = OUT_VALID_BIT + 1;
    localparam int OUT_DATA_W    = 96;

    typedef enum logic [1:0] {
        TOK_NONE,
        TOK_WORD,
        TOK_READ
    } tok_kind_t;

    // A token walks down the cell chain, one cell per cycle while the chain advances.
    typedef struct packed {
        tok_kind_t               kind;
        logic [KEY_W-1:0]        key;
        logic [OUT_COUNT_W-1:0]  count;
        logic                    valid;
        logic [IDX_W-1:0]        index;
    } token_t;

endpackage

>>> sv/fasta_kmer_counter_core.sv
// Top level of the FASTA k-mer counter: front end, chain of table cells, output register.
// Depends on fkc_pkg, fkc_front and fkc_cell.
//
// Usage. Input beats arrive on the s_axis group. tuser carries the operation: 0 streams
// the text byte in tdata[7:0], 1 reads the table slot given in tdata[15:8]. A '>' byte
// opens a header, a newline closes it, and every other byte outside a header enters a
// window of k bytes; once k bytes have arrived since the last header the word is counted.
// The word length k is written through kmer_length_we / kmer_length_wdata while idle.
// A stream beat gives no output; a read beat gives exactly one output beat on m_axis.
//
// Each word or read enters a row of TABLE_ENTRIES cells as a token and moves one cell per
// cycle while the chain advances. A cell that holds the same word bumps its saturating
// count; the first empty cell claims a new word, so slots fill in order of first
// appearance. A word that leaves the last cell unclaimed sets the sticky overflow flag.
// A read token picks up the entry of the cell whose position matches its slot number.
//
// One beat per cycle goes in and out while the chain advances. A read result passes the
// front-end token register, each cell's token register and the output register. When the
// receiver stalls with a result waiting and a read at the tail, the chain and input hold.
// Reset clears the window, header state, slot occupancy, overflow flag and output valid;
// k returns to 1. No clearing pass is needed.
module fasta_kmer_counter_core #(
    parameter int MAX_KMER_BYTES = 8,
    parameter int TABLE_ENTRIES  = 256,
    parameter int COUNT_BITS     = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               kmer_length_we,
    input  logic [fkc_pkg::KLEN_W-1:0]         kmer_length_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: text_byte [7:0], entry_index [15:8]
    input  logic [15:0]                        s_axis_tdata,
    // tuser: operation [0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: kmer_key [63:0], kmer_count [87:64], entry_valid [88], table_overflow [89],
    // zero padding [95:90]
    output logic [fkc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import fkc_pkg::*;

    token_t tok [TABLE_ENTRIES+1];

    logic                  advance;
    logic                  accept;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  overflow_reg, overflow_next;
    logic                  tail_read;

    // The chain moves unless a finished read sits at the tail with nowhere to go.
    assign tail_read     = (tok[TABLE_ENTRIES].kind == TOK_READ);
    assign advance       = !tail_read || !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    fkc_front #(
        .MAX_KMER_BYTES (MAX_KMER_BYTES)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .kmer_length_we    (kmer_length_we),
        .kmer_length_wdata (kmer_length_wdata),
        .accept            (accept),
        .operation         (s_axis_tuser),
        .text_byte         (s_axis_tdata[7:0]),
        .entry_index       (s_axis_tdata[15:8]),
        .advance           (advance),
        .tok_out           (tok[0])
    );

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        fkc_cell #(
            .CELL_INDEX (i),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    // A word that passed every cell unclaimed found the table full.
    always_comb
    begin
        overflow_next = overflow_reg;
        if (advance && tok[TABLE_ENTRIES].kind == TOK_WORD)
        begin
            overflow_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (advance && tail_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // The result beat is assembled from the read token at the tail.
    always_comb
    begin
        out_data_next                                = '0;
        out_data_next[OUT_KEY_LSB +: KEY_W]          = tok[TABLE_ENTRIES].key;
        out_data_next[OUT_COUNT_LSB +: OUT_COUNT_W]  = tok[TABLE_ENTRIES].count;
        out_data_next[OUT_VALID_BIT]                 = tok[TABLE_ENTRIES].valid;
        out_data_next[OUT_OVF_BIT]                   = overflow_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_read)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> sv/fkc_front.sv
// Front end of the FASTA k-mer counter: header tracking, byte window and token issue.
// Depends on fkc_pkg; feeds the first cell of the chain.
module fkc_front #(
    parameter int MAX_KMER_BYTES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        kmer_length_we,
    input  logic [fkc_pkg::KLEN_W-1:0]  kmer_length_wdata,
    input  logic                        accept,
    input  logic                        operation,
    input  logic [fkc_pkg::BYTE_W-1:0]  text_byte,
    input  logic [fkc_pkg::IDX_W-1:0]   entry_index,
    input  logic                        advance,
    output fkc_pkg::token_t             tok_out
);
    import fkc_pkg::*;

    localparam int WIN_W = 8 * MAX_KMER_BYTES;

    logic [KLEN_W-1:0] kmer_length_reg;
    logic [WIN_W-1:0]  window_reg, window_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              in_header_reg, in_header_next;
    token_t            tok_reg, tok_next;
    logic [KLEN_W-1:0] k_eff;
    logic [WIN_W-1:0]  mask;

    always_comb
    begin
        k_eff = kmer_length_reg;
        if (k_eff == '0)
        begin
            k_eff = KLEN_W'(1);
        end
        if (k_eff > KLEN_W'(MAX_KMER_BYTES))
        begin
            k_eff = KLEN_W'(MAX_KMER_BYTES);
        end
        for (int b = 0; b < MAX_KMER_BYTES; b++)
        begin
            mask[b*8 +: 8] = (KLEN_W'(b) < k_eff) ? 8'hFF : 8'h00;
        end
    end

    always_comb
    begin
        window_next    = window_reg;
        pos_next       = pos_reg;
        in_header_next = in_header_reg;
        tok_next       = '0;
        tok_next.kind  = TOK_NONE;
        if (accept)
        begin
            unique case (operation)
                OP_READ:
                begin
                    tok_next.kind  = TOK_READ;
                    tok_next.index = entry_index;
                end
                default:
                begin
                    if (text_byte == CHAR_HEADER)
                    begin
                        in_header_next = 1'b1;
                        pos_next       = '0;
                    end
                    else if (text_byte == CHAR_NEWLINE)
                    begin
                        in_header_next = 1'b0;
                    end
                    else if (!in_header_reg)
                    begin
                        if (WIN_W > 8)
                        begin
                            window_next = {window_reg[WIN_W-9:0], text_byte};
                        end
                        else
                        begin
                            window_next = WIN_W'(text_byte);
                        end
                        if (pos_reg != '1)
                        begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                        if (pos_next >= k_eff)
                        begin
                            tok_next.kind = TOK_WORD;
                            tok_next.key  = KEY_W'(window_next & mask);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KLEN_W'(1);
            window_reg      <= '0;
            pos_reg         <= '0;
            in_header_reg   <= 1'b0;
            tok_reg         <= '0;
        end
        else
        begin
            if (kmer_length_we)
            begin
                kmer_length_reg <= kmer_length_wdata;
            end
            window_reg    <= window_next;
            pos_reg       <= pos_next;
            in_header_reg <= in_header_next;
            if (advance)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> sv/fkc_cell.sv
// One table cell of the FASTA k-mer counter: holds one entry and passes tokens on.
// Depends on fkc_pkg; instantiated in a row by the top level.
module fkc_cell #(
    parameter int CELL_INDEX = 0,
    parameter int COUNT_BITS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  fkc_pkg::token_t tok_in,
    output fkc_pkg::token_t tok_out
);
    import fkc_pkg::*;

    logic [KEY_W-1:0]      key_reg, key_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  used_reg, used_next;
    token_t                tok_reg, tok_next;

    always_comb
    begin
        key_next   = key_reg;
        count_next = count_reg;
        used_next  = used_reg;
        tok_next   = tok_in;
        unique case (tok_in.kind)
            TOK_WORD:
            begin
                if (used_reg && key_reg == tok_in.key)
                begin
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                    tok_next.kind = TOK_NONE;
                end
                else if (!used_reg)
                begin
                    key_next      = tok_in.key;
                    count_next    = COUNT_BITS'(1);
                    used_next     = 1'b1;
                    tok_next.kind = TOK_NONE;
                end
            end
            TOK_READ:
            begin
                if (used_reg && 32'(tok_in.index) == 32'(CELL_INDEX))
                begin
                    tok_next.key   = key_reg;
                    tok_next.count = OUT_COUNT_W'(count_reg);
                    tok_next.valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else if (advance)
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg   <= key_next;
            count_reg <= count_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> sv/fkc_checker.sv
// Port-level checker for the FASTA k-mer counter, bound to the top level.
// Depends on fkc_pkg and on fasta_kmer_counter_core being compiled first.
module fkc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [fkc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import fkc_pkg::*;

    // A stalled beat stays offered.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat withdrawn while stalled");

    // A stalled beat keeps its payload.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output payload changed while stalled");

    // An empty or out-of-range slot reads as zero key and zero count.
    a_empty_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_VALID_BIT]
            |-> m_axis_tdata[OUT_VALID_BIT-1:0] == '0)
        else $error("empty slot returned a nonzero key or count");

    // Nothing is offered in the cycle after reset is seen.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output beat offered straight after reset");

endmodule

bind fasta_kmer_counter_core fkc_checker u_fkc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
